/* design/rrq_pkg.sv */
package rrq_pkg;

  // Widths of the fields on the item and result ports.
  localparam int MODE_W      = 3;
  localparam int CPU_FIELD_W = 3;
  localparam int ID_FIELD_W  = 8;

  // Configuration port layout.
  localparam int ACTIVE_W   = 4;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = 1;

  // Register indexes and their reset values.
  localparam int REG_ACTIVE_CPUS = 0;
  localparam logic [ACTIVE_W-1:0] ACTIVE_CPUS_RESET = 4'd8;

  // Operation codes carried in the mode field.
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK           = 3'd0,
    MODE_ENQUEUE        = 3'd1,
    MODE_REMOVE_THREAD  = 3'd2,
    MODE_REMOVE_PROCESS = 3'd3,
    MODE_FAULT          = 3'd4,
    MODE_QUERY          = 3'd5
  } mode_e;

  typedef logic [ID_FIELD_W-1:0] id_field_t;

  // One input word.
  typedef struct packed {
    mode_e                  mode;
    logic [CPU_FIELD_W-1:0] cpu;
    id_field_t              thread_id;
    id_field_t              process_id;
    logic                   preemptible;
  } item_t;

  // One result word.
  typedef struct packed {
    logic      switched;
    logic      has_thread;
    id_field_t run_thread;
    id_field_t run_process;
    logic      had_current;
    logic      queue_full;
  } result_t;

  localparam result_t RESULT_NONE = '0;

endpackage

/* design/rrq_ram.sv */
module rrq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/rrq_regs.sv */
module rrq_regs import rrq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [ACTIVE_W-1:0]   active_cpus_o
);

  logic [ACTIVE_W-1:0]  active_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 sel_active;
  logic                 wr_en;

  // Registers sit on 32-bit word boundaries.
  assign reg_idx    = paddr[APB_ADDR_W-1:2];
  assign sel_active = (reg_idx == REG_IDX_W'(REG_ACTIVE_CPUS));
  assign pready     = 1'b1;
  assign wr_en      = psel && penable && pwrite && pready;

  // Number of CPU slots that the remove operations scan.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACTIVE_CPUS_RESET;
    end else if (wr_en && sel_active) begin
      active_q <= pwdata[ACTIVE_W-1:0];
    end
  end

  // Read data.
  assign prdata        = sel_active ? APB_DATA_W'(active_q) : '0;
  assign active_cpus_o = active_q;

endmodule

/* design/rrq_engine.sv */
module rrq_engine import rrq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_CPUS    = 8,
  parameter int ID_BITS     = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  item_t               item_i,
  input  logic [ACTIVE_W-1:0] active_cpus_i,
  output logic                busy_o,
  output logic                done_o,
  output result_t             result_o
);

  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = QPTR_W + 1;
  localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int SCAN_W = $clog2(NUM_CPUS + 1);

  typedef logic [ID_BITS-1:0] id_t;
  typedef struct packed {
    id_t process;
    id_t thread;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CPU,
    ST_WALK,
    ST_SCAN
  } state_e;

  // Control state.
  state_e              state_q, state_d;
  logic [QPTR_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [NUM_CPUS-1:0] cpu_busy_q, cpu_busy_d;
  logic                done_q, done_d;
  result_t             result_q, result_d;

  // Working registers of the current operation.
  item_t               item_q, item_d;
  logic [QPTR_W-1:0]   src_q, src_d;
  logic [QPTR_W-1:0]   dst_q, dst_d;
  logic [CNT_W-1:0]    rem_q, rem_d;
  logic [CNT_W-1:0]    kept_q, kept_d;
  logic                pend_q, pend_d;
  logic [SCAN_W-1:0]   scan_q, scan_d;
  logic                scan_pend_q, scan_pend_d;
  logic [CPU_W-1:0]    scan_idx_q, scan_idx_d;

  // Memory ports.
  logic              q_we;
  logic [QPTR_W-1:0] q_waddr;
  entry_t            q_wdata;
  logic [QPTR_W-1:0] q_raddr;
  entry_t            q_rdata;
  logic              c_we;
  logic [CPU_W-1:0]  c_waddr;
  entry_t            c_wdata;
  logic [CPU_W-1:0]  c_raddr;
  entry_t            c_rdata;

  // Derived values.
  logic [CNT_W-1:0]  tail_sum;
  logic [QPTR_W-1:0] tail_ptr;
  logic              in_cpu_ok;
  logic [CPU_W-1:0]  cidx;
  logic              busy_c;
  logic              queue_ne;
  logic              by_process;
  id_t               key;
  id_t               q_key;
  id_t               c_key;
  logic [SCAN_W-1:0] scan_lim;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Queue of waiting (thread, process) pairs.
  rrq_ram #(
    .WIDTH (2 * ID_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  // Current thread of each CPU.
  rrq_ram #(
    .WIDTH (2 * ID_BITS),
    .DEPTH (NUM_CPUS)
  ) u_cpu_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  // Tail slot of the queue, wrapping at the depth.
  assign tail_sum = CNT_W'(head_q) + count_q;
  assign tail_ptr = (tail_sum >= CNT_W'(QUEUE_DEPTH)) ?
                    QPTR_W'(tail_sum - CNT_W'(QUEUE_DEPTH)) : QPTR_W'(tail_sum);

  assign in_cpu_ok = (32'(item_i.cpu) < NUM_CPUS);
  assign cidx      = CPU_W'(item_q.cpu);
  assign busy_c    = cpu_busy_q[cidx];
  assign queue_ne  = (count_q != '0);

  // Match keys for the remove operations.
  assign by_process = (item_q.mode == MODE_REMOVE_PROCESS);
  assign key        = by_process ? id_t'(item_q.process_id) : id_t'(item_q.thread_id);
  assign q_key      = by_process ? q_rdata.process : q_rdata.thread;
  assign c_key      = by_process ? c_rdata.process : c_rdata.thread;

  // Slots scanned, limited to the CPUs that exist.
  assign scan_lim = (32'(active_cpus_i) > NUM_CPUS) ? SCAN_W'(NUM_CPUS)
                                                    : SCAN_W'(active_cpus_i);

  // Sequencer: decode, read-modify-write of the memories, queue compaction and slot scan.
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    cpu_busy_d  = cpu_busy_q;
    done_d      = 1'b0;
    result_d    = result_q;
    item_d      = item_q;
    src_d       = src_q;
    dst_d       = dst_q;
    rem_d       = rem_q;
    kept_d      = kept_q;
    pend_d      = pend_q;
    scan_d      = scan_q;
    scan_pend_d = scan_pend_q;
    scan_idx_d  = scan_idx_q;
    q_we        = 1'b0;
    q_waddr     = tail_ptr;
    q_wdata     = c_rdata;
    q_raddr     = head_q;
    c_we        = 1'b0;
    c_waddr     = cidx;
    c_wdata     = q_rdata;
    c_raddr     = cidx;

    case (state_q)
      ST_IDLE: begin
        c_raddr = CPU_W'(item_i.cpu);
        if (start_i) begin
          item_d = item_i;
          case (item_i.mode)
            MODE_ENQUEUE: begin
              done_d   = 1'b1;
              result_d = RESULT_NONE;
              if (count_q == CNT_W'(QUEUE_DEPTH)) begin
                result_d.queue_full = 1'b1;
              end else begin
                q_we    = 1'b1;
                q_wdata = '{process: id_t'(item_i.process_id),
                            thread:  id_t'(item_i.thread_id)};
                count_d = count_q + 1'b1;
              end
            end
            MODE_REMOVE_THREAD, MODE_REMOVE_PROCESS: begin
              src_d   = head_q;
              dst_d   = head_q;
              rem_d   = count_q;
              kept_d  = '0;
              pend_d  = 1'b0;
              state_d = ST_WALK;
            end
            MODE_TICK, MODE_FAULT, MODE_QUERY: begin
              if (in_cpu_ok) begin
                state_d = ST_CPU;
              end else begin
                done_d   = 1'b1;
                result_d = RESULT_NONE;
              end
            end
            default: begin
              done_d   = 1'b1;
              result_d = RESULT_NONE;
            end
          endcase
        end
      end

      ST_CPU: begin
        done_d   = 1'b1;
        state_d  = ST_IDLE;
        result_d = RESULT_NONE;
        case (item_q.mode)
          MODE_TICK: begin
            if (item_q.preemptible && queue_ne) begin
              // Pop the head, requeue the running thread, install the popped one.
              head_d = ptr_inc(head_q);
              if (busy_c) begin
                q_we = 1'b1;
              end else begin
                count_d = count_q - 1'b1;
              end
              c_we                 = 1'b1;
              cpu_busy_d[cidx]     = 1'b1;
              result_d.switched    = 1'b1;
              result_d.has_thread  = 1'b1;
              result_d.run_thread  = id_field_t'(q_rdata.thread);
              result_d.run_process = id_field_t'(q_rdata.process);
            end else if (busy_c) begin
              result_d.has_thread  = 1'b1;
              result_d.run_thread  = id_field_t'(c_rdata.thread);
              result_d.run_process = id_field_t'(c_rdata.process);
            end
          end
          MODE_FAULT: begin
            // The faulting thread is dropped; a switch is tried only if one ran.
            result_d.had_current = busy_c;
            if (busy_c && item_q.preemptible && queue_ne) begin
              head_d               = ptr_inc(head_q);
              count_d              = count_q - 1'b1;
              c_we                 = 1'b1;
              result_d.switched    = 1'b1;
              result_d.has_thread  = 1'b1;
              result_d.run_thread  = id_field_t'(q_rdata.thread);
              result_d.run_process = id_field_t'(q_rdata.process);
            end else begin
              cpu_busy_d[cidx] = 1'b0;
            end
          end
          default: begin
            if (busy_c) begin
              result_d.has_thread  = 1'b1;
              result_d.run_thread  = id_field_t'(c_rdata.thread);
              result_d.run_process = id_field_t'(c_rdata.process);
            end
          end
        endcase
      end

      ST_WALK: begin
        // Read one entry a cycle; the entry read last cycle is kept or dropped.
        q_raddr = src_q;
        if (rem_q != '0) begin
          src_d  = ptr_inc(src_q);
          rem_d  = rem_q - 1'b1;
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q && (q_key != key)) begin
          q_we    = 1'b1;
          q_waddr = dst_q;
          q_wdata = q_rdata;
          dst_d   = ptr_inc(dst_q);
          kept_d  = kept_q + 1'b1;
        end
        if (rem_q == '0) begin
          count_d = kept_d;
          if (kept_d == '0) begin
            head_d = '0;
          end
          scan_d      = '0;
          scan_pend_d = 1'b0;
          state_d     = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Read one CPU slot a cycle; a matching busy slot is released.
        c_raddr = scan_q[CPU_W-1:0];
        if (scan_q < scan_lim) begin
          scan_d      = scan_q + 1'b1;
          scan_idx_d  = scan_q[CPU_W-1:0];
          scan_pend_d = 1'b1;
        end else begin
          scan_pend_d = 1'b0;
        end
        if (scan_pend_q && cpu_busy_q[scan_idx_q] && (c_key == key)) begin
          cpu_busy_d[scan_idx_q] = 1'b0;
        end
        if (scan_q >= scan_lim) begin
          done_d   = 1'b1;
          result_d = RESULT_NONE;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_q     <= '0;
      count_q    <= '0;
      cpu_busy_q <= '0;
      done_q     <= 1'b0;
      result_q   <= RESULT_NONE;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      count_q    <= count_d;
      cpu_busy_q <= cpu_busy_d;
      done_q     <= done_d;
      result_q   <= result_d;
    end
  end

  // Working registers, always loaded before use.
  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    src_q       <= src_d;
    dst_q       <= dst_d;
    rem_q       <= rem_d;
    kept_q      <= kept_d;
    pend_q      <= pend_d;
    scan_q      <= scan_d;
    scan_pend_q <= scan_pend_d;
    scan_idx_q  <= scan_idx_d;
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

/* design/multicore_round_robin_run_queue.sv */
// Enqueue and the no-op cases give their result word in the cycle after acceptance;
// tick, fault and query first read the queue and CPU memories, then write them.
// Remove thread or process runs a compaction that walks the queue memory one entry a
// cycle, then the CPU memory one slot a cycle.
// A new word is accepted in the cycle its predecessor's result is shown; results cannot stall.
// Reset empties the queue, marks every CPU idle and sets active_cpus to 8.
module multicore_round_robin_run_queue import rrq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_CPUS    = 8,
  parameter int ID_BITS     = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  start,
  output logic                  busy,
  input  item_t                 item_i,
  output logic                  done_o,
  output result_t               result_o
);

  logic [ACTIVE_W-1:0] active_cpus;

  // Configuration register.
  rrq_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .active_cpus_o (active_cpus)
  );

  // Scheduler engine with its queue and CPU memories.
  rrq_engine #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_CPUS    (NUM_CPUS),
    .ID_BITS     (ID_BITS)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .item_i        (item_i),
    .active_cpus_i (active_cpus),
    .busy_o        (busy),
    .done_o        (done_o),
    .result_o      (result_o)
  );

endmodule

/* design/rrq_checker.sv */
module rrq_checker import rrq_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input logic    busy,
  input logic    done_o,
  input result_t result_o
);

  // A result word only follows an accepted word or a busy cycle.
  a_done_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(start && !busy) || $past(busy)))
    else $error("result word without a preceding operation");

  // Leaving the busy state always delivers the result word.
  a_busy_ends_in_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("operation finished without a result word");

  // A switch always leaves a thread installed.
  a_switch_has_thread: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.switched) |-> result_o.has_thread)
    else $error("switch reported with no thread installed");

  // Without a current thread the id fields read zero.
  a_idle_ids_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.has_thread) |->
      ((result_o.run_thread == '0) && (result_o.run_process == '0)))
    else $error("ids reported for an idle CPU");

endmodule

bind multicore_round_robin_run_queue rrq_checker u_rrq_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import rrq_pkg::*;

  localparam int QDEPTH      = 16;
  localparam int NCPU        = 8;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_WORDS = 458;

  // Mode codes that the block does not decode.
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  // Byte address of the active CPU count register.
  localparam logic [APB_ADDR_W-1:0] ACTIVE_CPUS_ADDR = APB_ADDR_W'(REG_ACTIVE_CPUS * 4);

  logic                  clk;
  logic                  rst_ni  = 1'b0;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  start   = 1'b0;
  logic                  busy;
  item_t                 item_word = '0;
  logic                  done;
  result_t               result_word;

  // Words waiting to be issued and scheduler outcomes still to arrive.
  item_t   words_to_issue[$];
  result_t predicted_outcomes[$];

  logic word_taken  = 1'b0;
  logic steady_feed = 1'b0;
  int   fail_count  = 0;
  int   cycle_count = 0;

  // Shadow of the scheduler state.
  id_field_t           rq_thread[QDEPTH];
  id_field_t           rq_process[QDEPTH];
  int                  rq_head = 0;
  int                  rq_len  = 0;
  id_field_t           slot_thread[NCPU];
  id_field_t           slot_process[NCPU];
  logic [NCPU-1:0]     slot_live = '0;
  logic [ACTIVE_W-1:0] active_slots = ACTIVE_CPUS_RESET;

  result_t want;

  multicore_round_robin_run_queue #(
    .QUEUE_DEPTH(QDEPTH),
    .NUM_CPUS   (NCPU),
    .ID_BITS    (ID_FIELD_W)
  ) dut (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .start   (start),
    .busy    (busy),
    .item_i  (item_word),
    .done_o  (done),
    .result_o(result_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Append an entry at the tail of the shadow run queue.
  function automatic void append_entry(input id_field_t t, input id_field_t p);
    int pos;
    pos = (rq_head + rq_len) % QDEPTH;
    rq_thread[pos]  = t;
    rq_process[pos] = p;
    rq_len++;
  endfunction

  // Pop the head onto a CPU, sending its current thread to the tail.
  function automatic logic rotate_in(input int c, input logic preempt);
    id_field_t t;
    id_field_t p;
    if (!preempt || rq_len == 0) return 1'b0;
    t = rq_thread[rq_head];
    p = rq_process[rq_head];
    rq_head = (rq_head + 1) % QDEPTH;
    rq_len--;
    if (slot_live[c]) append_entry(slot_thread[c], slot_process[c]);
    slot_thread[c]  = t;
    slot_process[c] = p;
    slot_live[c]    = 1'b1;
    return 1'b1;
  endfunction

  // Drop every queued or running entry whose thread or process equals the key.
  function automatic void purge_matching(input id_field_t key, input logic by_process);
    int        kept;
    int        src;
    int        dst;
    int        scan;
    id_field_t v;
    kept = 0;
    for (int i = 0; i < rq_len; i++) begin
      src = (rq_head + i) % QDEPTH;
      v   = by_process ? rq_process[src] : rq_thread[src];
      if (v != key) begin
        dst = (rq_head + kept) % QDEPTH;
        rq_thread[dst]  = rq_thread[src];
        rq_process[dst] = rq_process[src];
        kept++;
      end
    end
    rq_len = kept;
    if (rq_len == 0) rq_head = 0;
    scan = (active_slots > NCPU) ? NCPU : int'(active_slots);
    for (int i = 0; i < scan; i++) begin
      v = by_process ? slot_process[i] : slot_thread[i];
      if (slot_live[i] && v == key) slot_live[i] = 1'b0;
    end
  endfunction

  // Work out the result word of one accepted command and advance the shadow.
  function automatic result_t schedule_outcome(input item_t w);
    result_t r;
    int      c;
    r = RESULT_NONE;
    c = int'(w.cpu);
    case (w.mode)
      MODE_ENQUEUE: begin
        if (rq_len >= QDEPTH) r.queue_full = 1'b1;
        else append_entry(w.thread_id, w.process_id);
      end
      MODE_REMOVE_THREAD: begin
        purge_matching(w.thread_id, 1'b0);
      end
      MODE_REMOVE_PROCESS: begin
        purge_matching(w.process_id, 1'b1);
      end
      MODE_TICK, MODE_FAULT, MODE_QUERY: begin
        if (c < NCPU) begin
          if (w.mode == MODE_TICK) begin
            r.switched = rotate_in(c, w.preemptible);
          end else if (w.mode == MODE_FAULT) begin
            r.had_current = slot_live[c];
            slot_live[c]  = 1'b0;
            if (r.had_current) r.switched = rotate_in(c, w.preemptible);
          end
          if (slot_live[c]) begin
            r.has_thread  = 1'b1;
            r.run_thread  = slot_thread[c];
            r.run_process = slot_process[c];
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(input string field, input int unsigned expv,
                                      input int unsigned gotv);
    if (expv != gotv) begin
      $display("%0t: %s expected %0h, got %0h", $time, field, expv, gotv);
      fail_count++;
    end
  endfunction

  // Ids mostly come from small pools so that removals find matches.
  function automatic id_field_t pick_thread();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return id_field_t'($urandom_range(0, 15));
    return id_field_t'($urandom_range(0, 255));
  endfunction

  function automatic id_field_t pick_process();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 8) return id_field_t'($urandom_range(0, 3));
    return id_field_t'($urandom_range(0, 255));
  endfunction

  function automatic item_t make_word(input mode_e m, input int c, input int t, input int p,
                                      input logic pre);
    item_t w;
    w.mode        = m;
    w.cpu         = c[CPU_FIELD_W-1:0];
    w.thread_id   = t[ID_FIELD_W-1:0];
    w.process_id  = p[ID_FIELD_W-1:0];
    w.preemptible = pre;
    return w;
  endfunction

  function automatic item_t fresh_word(input mode_e m);
    return make_word(m, $urandom_range(0, NCPU - 1), pick_thread(), pick_process(),
                     $urandom_range(0, 99) < 85);
  endfunction

  // Queue a random phase built from bursts of like commands.
  task automatic queue_random_phase(input int n);
    int    issued;
    int    kind;
    int    len;
    item_t w;
    issued = 0;
    while (issued < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        len = $urandom_range(1, 20);
        repeat (len) words_to_issue.push_back(fresh_word(MODE_ENQUEUE));
      end else if (kind < 75) begin
        len = $urandom_range(1, 10);
        repeat (len) words_to_issue.push_back(fresh_word(MODE_TICK));
      end else if (kind < 85) begin
        len = $urandom_range(1, 3);
        repeat (len) words_to_issue.push_back(fresh_word(MODE_FAULT));
      end else if (kind < 93) begin
        len = 1;
        if ($urandom_range(0, 1) == 0) words_to_issue.push_back(fresh_word(MODE_REMOVE_THREAD));
        else words_to_issue.push_back(fresh_word(MODE_REMOVE_PROCESS));
      end else if (kind < 98) begin
        len = $urandom_range(1, 3);
        repeat (len) words_to_issue.push_back(fresh_word(MODE_QUERY));
      end else begin
        // Noise: any mode, any field value.
        w = make_word(mode_e'($urandom_range(0, 7)), $urandom_range(0, 7),
                      $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1));
        words_to_issue.push_back(w);
        len = (w.mode <= MODE_QUERY) ? 1 : 0;
      end
      issued += len;
    end
  endtask

  // Wait until every command has been issued and every result has come back.
  task automatic wait_idle();
    do @(posedge clk);
    while (words_to_issue.size() != 0 || start || predicted_outcomes.size() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  // Write the active CPU count over the APB port and read it back.
  task automatic program_active(input logic [ACTIVE_W-1:0] v);
    logic [APB_DATA_W-1:0] readback;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ACTIVE_CPUS_ADDR;
    pwdata  <= APB_DATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    active_slots = v;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[ACTIVE_W-1:0] !== v) begin
      $display("%0t: active_cpus readback expected %0h, got %0h", $time, v, readback);
      fail_count++;
    end
  endtask

  // Driver: present the next word at the falling edge once the previous one is taken.
  always @(negedge clk) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || word_taken) begin
      if (words_to_issue.size() != 0 && (steady_feed || $urandom_range(0, 99) >= 33)) begin
        item_word <= words_to_issue.pop_front();
        start     <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check each result word, then predict the word accepted at this edge.
  always @(posedge clk) begin
    word_taken = rst_ni && start && !busy;
    if (rst_ni && done) begin
      if (predicted_outcomes.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %h", $time, result_word);
        fail_count++;
      end else begin
        want = predicted_outcomes.pop_front();
        check_field("switched", want.switched, result_word.switched);
        check_field("has_thread", want.has_thread, result_word.has_thread);
        check_field("run_thread", want.run_thread, result_word.run_thread);
        check_field("run_process", want.run_process, result_word.run_process);
        check_field("had_current", want.had_current, result_word.had_current);
        check_field("queue_full", want.queue_full, result_word.queue_full);
      end
    end
    if (word_taken) predicted_outcomes.push_back(schedule_outcome(item_word));
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // Directed part: idle CPUs, extreme ids, failed and successful switches.
    words_to_issue.push_back(make_word(MODE_QUERY, 0, 0, 0, 1'b1));
    words_to_issue.push_back(make_word(MODE_TICK, 0, 0, 0, 1'b1));
    words_to_issue.push_back(make_word(MODE_FAULT, 1, 0, 0, 1'b1));
    words_to_issue.push_back(make_word(MODE_ENQUEUE, 7, 255, 255, 1'b1));
    words_to_issue.push_back(make_word(MODE_ENQUEUE, 0, 0, 0, 1'b0));
    words_to_issue.push_back(make_word(MODE_TICK, 7, 0, 0, 1'b0));
    words_to_issue.push_back(make_word(MODE_TICK, 7, 255, 255, 1'b1));
    words_to_issue.push_back(make_word(MODE_TICK, 7, 0, 0, 1'b1));
    words_to_issue.push_back(make_word(MODE_FAULT, 7, 0, 0, 1'b1));
    words_to_issue.push_back(make_word(MODE_FAULT, 7, 0, 0, 1'b0));
    // Removal of queued and running entries, by thread and by process.
    words_to_issue.push_back(make_word(MODE_ENQUEUE, 0, 8'h55, 8'hAA, 1'b0));
    words_to_issue.push_back(make_word(MODE_ENQUEUE, 0, 8'h56, 8'hAA, 1'b0));
    words_to_issue.push_back(make_word(MODE_ENQUEUE, 0, 8'h55, 8'h01, 1'b0));
    words_to_issue.push_back(make_word(MODE_TICK, 0, 0, 0, 1'b1));
    words_to_issue.push_back(make_word(MODE_REMOVE_THREAD, 0, 8'h55, 0, 1'b0));
    words_to_issue.push_back(make_word(MODE_QUERY, 0, 0, 0, 1'b0));
    words_to_issue.push_back(make_word(MODE_TICK, 3, 0, 0, 1'b1));
    words_to_issue.push_back(make_word(MODE_REMOVE_PROCESS, 0, 0, 8'hAA, 1'b0));
    words_to_issue.push_back(make_word(MODE_QUERY, 3, 0, 0, 1'b1));
    // Undecoded modes change nothing.
    words_to_issue.push_back(make_word(mode_e'(MODE_SPARE_LO), 5, 255, 255, 1'b1));
    words_to_issue.push_back(make_word(mode_e'(MODE_SPARE_HI), 2, 0, 0, 1'b1));

    // Random phases at several active CPU counts; the second runs without gaps.
    wait_idle();
    program_active(4'd1);
    queue_random_phase(PHASE_WORDS);
    wait_idle();
    program_active(4'd8);
    steady_feed = 1'b1;
    queue_random_phase(PHASE_WORDS);
    wait_idle();
    steady_feed = 1'b0;
    program_active(ACTIVE_W'($urandom_range(2, 7)));
    queue_random_phase(PHASE_WORDS);
    wait_idle();
    program_active(4'd8);
    queue_random_phase(PHASE_WORDS);

    wait_idle();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
